// ===== rtl/cartridge_bank_controller_assert.svh =====
// assertion macros for the cartridge bank controller
// each use expects clk and arst_n in scope
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define CBC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("cartridge bank controller assertion failed");
`define CBC_NEVER(name, cond) `CBC_ASSERT(name, !(cond))
`else
`define CBC_ASSERT(name, prop)
`define CBC_NEVER(name, cond)
`endif
`endif

// ===== rtl/cbc_pkg.sv =====
`default_nettype none

package cbc_pkg;

	// field and register widths
	localparam int ROM_AW = 23;
	localparam int RAM_IW = 17;
	localparam int CFG_W  = 23;

	// parameter defaults
	localparam int DEF_RAM_BYTES     = 131072;
	localparam int DEF_ROM_ADDR_BITS = 23;

	// controller kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_MBC1 = 2'd1;
	localparam logic [1:0] KIND_MBC2 = 2'd2;
	localparam logic [1:0] KIND_MBC5 = 2'd3;

	// request types
	localparam logic [1:0] REQ_ROM_READ  = 2'd0;
	localparam logic [1:0] REQ_REG_WRITE = 2'd1;
	localparam logic [1:0] REQ_RAM_READ  = 2'd2;
	localparam logic [1:0] REQ_RAM_WRITE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_KIND     = 2'd0;
	localparam logic [1:0] CFG_RAM_PRES = 2'd1;
	localparam logic [1:0] CFG_ROM_MASK = 2'd2;
	localparam logic [1:0] CFG_RAM_MASK = 2'd3;

	// configuration reset values
	localparam logic [ROM_AW-1:0] ROM_MASK_RST = 23'h007FFF;
	localparam logic [RAM_IW-1:0] RAM_MASK_RST = 17'h01FFF;

	// bus address boundaries
	localparam logic [15:0] ADDR_ENABLE_TOP = 16'h1FFF;
	localparam logic [15:0] ADDR_BANK0_TOP  = 16'h3FFF;
	localparam logic [15:0] ADDR_MBC5_LOW   = 16'h2FFF;
	localparam logic [15:0] ADDR_HIGH_TOP   = 16'h5FFF;

	localparam logic [7:0] ENABLE_CODE = 8'h0A;
	localparam logic [RAM_IW-1:0] MBC2_RAM_MASK = 17'h001FF;
	localparam logic [7:0] RAM_FILL = 8'hFF;

	// decoded request for the current bus access
	typedef struct packed {
		logic              fetch;
		logic [ROM_AW-1:0] rom_address;
		logic              ram_rd;
		logic              ram_wr;
		logic              ram_hit;
		logic [RAM_IW-1:0] ram_index;
		logic [7:0]        ram_wdata;
		logic              mbc2;
	} req_decode_t;

	// cartridge ram command
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [RAM_IW-1:0] index;
		logic [7:0]        wdata;
	} ram_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cartridge_bank_controller.sv =====
// an input transfer passes the stage 1 and output registers; one item per cycle
// sustained unless out_stall or the clearing pass holds it; the bank registers and
// ram index are resolved in the accept cycle, the ram read lands in stage 1, the
// result sits in the output register; reset: bank registers, configuration and
// pipeline valids reset asynchronously, then a clearing pass fills the cartridge ram
// with 0xFF, during which in_stall stays high (configuration writes are still taken)
`default_nettype none
`include "cartridge_bank_controller_assert.svh"

module cartridge_bank_controller import cbc_pkg::*; #(
	parameter int RAM_BYTES     = DEF_RAM_BYTES,
	parameter int ROM_ADDR_BITS = DEF_ROM_ADDR_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [15:0]       bus_address,
	input  wire logic [7:0]        write_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             read_data,
	output logic                   rom_fetch,
	output logic [ROM_AW-1:0]      rom_address
);

	req_decode_t decode;
	ram_cmd_t    ram_cmd;
	logic        clearing;
	logic [7:0]  ram_rdata;
	logic        accept;
	logic        s1_adv;

	logic              valid_s1;
	logic              fetch_s1;
	logic [ROM_AW-1:0] rom_address_s1;
	logic              ram_rd_s1;
	logic              hit_s1;
	logic              mbc2_s1;
	logic [7:0]        rd_s1;

	logic              out_valid_q;
	logic [7:0]        read_data_q;
	logic              rom_fetch_q;
	logic [ROM_AW-1:0] rom_address_q;

	cbc_bank #(
		.ROM_ADDR_BITS(ROM_ADDR_BITS)
	) u_bank (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.req_type(req_type),
		.bus_address(bus_address),
		.write_data(write_data),
		.decode(decode)
	);

	// ram command issued in the accept cycle
	always_comb begin
		ram_cmd.rd    = accept && decode.ram_rd && decode.ram_hit;
		ram_cmd.wr    = accept && decode.ram_wr && decode.ram_hit;
		ram_cmd.index = decode.ram_index;
		ram_cmd.wdata = decode.ram_wdata;
	end

	cbc_ram #(
		.RAM_BYTES(RAM_BYTES)
	) u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(ram_cmd),
		.clearing(clearing),
		.rdata(ram_rdata)
	);

	// flow control
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = clearing || (valid_s1 && !s1_adv);
	assign accept   = in_valid && !in_stall;

	// stage 1: waits on the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fetch_s1       <= decode.fetch;
			rom_address_s1 <= decode.fetch ? decode.rom_address : '0;
			ram_rd_s1      <= decode.ram_rd;
			hit_s1         <= decode.ram_hit;
			mbc2_s1        <= decode.mbc2;
		end
	end

	// read data merge: non-ram requests give zero, disabled or absent ram reads all ones
	always_comb begin
		if (!ram_rd_s1) begin
			rd_s1 = 8'd0;
		end else if (!hit_s1) begin
			rd_s1 = RAM_FILL;
		end else if (mbc2_s1) begin
			rd_s1 = {4'hF, ram_rdata[3:0]};
		end else begin
			rd_s1 = ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			read_data_q   <= rd_s1;
			rom_fetch_q   <= fetch_s1;
			rom_address_q <= rom_address_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign rom_fetch   = rom_fetch_q;
	assign rom_address = rom_address_q;

	// checks
	`CBC_ASSERT(a_accept_fills_s1, accept |=> valid_s1)
	`CBC_ASSERT(a_s1_hold_rdata, (valid_s1 && !s1_adv) |=> $stable(ram_rdata))
	`CBC_ASSERT(a_clear_once, !clearing |=> !clearing)
	`CBC_NEVER(a_fetch_no_data, out_valid && rom_fetch && (read_data != 8'd0))

endmodule

`default_nettype wire

// ===== rtl/cbc_bank.sv =====
`default_nettype none

module cbc_bank import cbc_pkg::*; #(
	parameter int ROM_ADDR_BITS = DEF_ROM_ADDR_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              accept,
	input  wire logic [1:0]        req_type,
	input  wire logic [15:0]       bus_address,
	input  wire logic [7:0]        write_data,
	output req_decode_t            decode
);

	localparam logic [ROM_AW-1:0] ROM_LIMIT =
		ROM_AW'((64'd1 << ROM_ADDR_BITS) - 64'd1);

	logic [1:0]        kind_q;
	logic              ram_present_q;
	logic [ROM_AW-1:0] rom_mask_q;
	logic [RAM_IW-1:0] ram_mask_q;

	logic [7:0] low_bank_q;
	logic [1:0] high_bank_q;
	logic [3:0] ram_page_q;
	logic       ram_enabled_q;
	logic       banking_mode_q;

	logic       low_area;
	logic [9:0] bank_sel;
	logic [23:0] rom_lin;
	logic [12:0] ram_off;
	logic [RAM_IW-1:0] ram_idx;
	logic       ram_ok;
	logic       reg_we;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= KIND_NONE;
			ram_present_q <= 1'b0;
			rom_mask_q    <= ROM_MASK_RST;
			ram_mask_q    <= RAM_MASK_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KIND:     kind_q        <= cfg_data[1:0];
				CFG_RAM_PRES: ram_present_q <= cfg_data[0];
				CFG_ROM_MASK: rom_mask_q    <= cfg_data[ROM_AW-1:0];
				CFG_RAM_MASK: ram_mask_q    <= cfg_data[RAM_IW-1:0];
				default: ;
			endcase
		end
	end

	assign reg_we = accept && (req_type == REQ_REG_WRITE);

	// bank and mode registers, written by bus transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bank_q     <= 8'd1;
			high_bank_q    <= 2'd0;
			ram_page_q     <= 4'd0;
			ram_enabled_q  <= 1'b0;
			banking_mode_q <= 1'b0;
		end else if (reg_we) begin
			case (kind_q)
				KIND_MBC1: begin
					if (bus_address <= ADDR_ENABLE_TOP) begin
						ram_enabled_q <= (write_data[3:0] == ENABLE_CODE[3:0]);
					end else if (bus_address <= ADDR_BANK0_TOP) begin
						low_bank_q <= (write_data[4:0] != 5'd0) ?
							{3'd0, write_data[4:0]} : 8'd1;
					end else if (bus_address <= ADDR_HIGH_TOP) begin
						high_bank_q <= write_data[1:0];
					end else begin
						banking_mode_q <= write_data[0];
					end
				end
				KIND_MBC2: begin
					if (bus_address <= ADDR_BANK0_TOP) begin
						if (!bus_address[8]) begin
							ram_enabled_q <= (write_data[3:0] == ENABLE_CODE[3:0]);
						end else begin
							low_bank_q <= (write_data[3:0] != 4'd0) ?
								{4'd0, write_data[3:0]} : 8'd1;
						end
					end
				end
				KIND_MBC5: begin
					if (bus_address <= ADDR_ENABLE_TOP) begin
						ram_enabled_q <= (write_data == ENABLE_CODE);
					end else if (bus_address <= ADDR_MBC5_LOW) begin
						low_bank_q <= write_data;
					end else if (bus_address <= ADDR_BANK0_TOP) begin
						high_bank_q <= {1'b0, write_data[0]};
					end else if (bus_address <= ADDR_HIGH_TOP) begin
						ram_page_q <= write_data[3:0];
					end
				end
				default: ;
			endcase
		end
	end

	// rom bank selection
	assign low_area = (bus_address <= ADDR_BANK0_TOP);

	always_comb begin
		bank_sel = 10'd0;
		if (low_area) begin
			if (kind_q == KIND_MBC1 && banking_mode_q) begin
				bank_sel = {3'd0, high_bank_q, 5'd0};
			end
		end else begin
			case (kind_q)
				KIND_NONE: bank_sel = 10'd1;
				KIND_MBC1: bank_sel = {3'd0, high_bank_q, 5'd0} | {2'd0, low_bank_q};
				KIND_MBC2: bank_sel = {2'd0, low_bank_q};
				default:   bank_sel = {high_bank_q, low_bank_q};
			endcase
		end
	end

	assign rom_lin = {bank_sel, bus_address[13:0]};

	// ram index and access permission
	assign ram_off = bus_address[12:0];

	always_comb begin
		ram_idx = '0;
		ram_ok  = 1'b0;
		case (kind_q)
			KIND_MBC1: begin
				ram_idx = {2'd0, (banking_mode_q ? high_bank_q : 2'd0), ram_off}
					& ram_mask_q;
				ram_ok  = ram_present_q;
			end
			KIND_MBC2: begin
				ram_idx = {4'd0, ram_off} & ram_mask_q & MBC2_RAM_MASK;
				ram_ok  = 1'b1;
			end
			KIND_MBC5: begin
				ram_idx = {ram_page_q, ram_off} & ram_mask_q;
				ram_ok  = ram_present_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		decode.fetch       = (req_type == REQ_ROM_READ);
		decode.rom_address = rom_lin[ROM_AW-1:0] & rom_mask_q & ROM_LIMIT;
		decode.ram_rd      = (req_type == REQ_RAM_READ);
		decode.ram_wr      = (req_type == REQ_RAM_WRITE);
		decode.ram_hit     = ram_ok && ram_enabled_q;
		decode.ram_index   = ram_idx;
		decode.mbc2        = (kind_q == KIND_MBC2);
		decode.ram_wdata   = (kind_q == KIND_MBC2) ? {4'd0, write_data[3:0]} : write_data;
	end

endmodule

`default_nettype wire

// ===== rtl/cbc_ram.sv =====
`default_nettype none

module cbc_ram import cbc_pkg::*; #(
	parameter int RAM_BYTES = DEF_RAM_BYTES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ram_cmd_t   cmd,
	output logic            clearing,
	output logic [7:0]      rdata
);

	// RAM_BYTES must be a power of two, which the block does not check; the index wraps on its low bits
	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0]    mem [RAM_BYTES];
	logic          clear_q;
	logic [AW-1:0] clr_addr_q;
	logic [7:0]    rdata_q;
	logic [AW-1:0] idx;

	assign idx = cmd.index[AW-1:0];

	// clearing pass after reset, one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				clear_q <= 1'b0;
			end
		end
	end

	// single port array, registered read
	always_ff @(posedge clk) begin
		if (clear_q) begin
			mem[clr_addr_q] <= RAM_FILL;
		end else if (cmd.wr) begin
			mem[idx] <= cmd.wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx];
		end
	end

	assign clearing = clear_q;
	assign rdata    = rdata_q;

endmodule

`default_nettype wire

// ===== tb/bank_access_checker.sv =====
`timescale 1ns / 1ps

module bank_access_checker import cbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [15:0]       bus_address,
	input  logic [7:0]        write_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        read_data,
	input  logic              rom_fetch,
	input  logic [ROM_AW-1:0] rom_address,
	output int                mismatch_count,
	output int                responses_due
);

	localparam logic [31:0] ROM_OFFSET_MASK = 32'h3FFF;
	localparam logic [31:0] RAM_OFFSET_MASK = 32'h1FFF;
	localparam logic [31:0] ROM_BANK_BYTES  = 32'h4000;
	localparam logic [31:0] RAM_BANK_BYTES  = 32'h2000;
	localparam int          MBC1_HIGH_SHIFT = 5;
	localparam int          MBC5_HIGH_SHIFT = 8;
	localparam logic [7:0]  NIBBLE_FILL     = 8'hF0;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              rom_fetch;
		logic [ROM_AW-1:0] rom_address;
	} bus_response_t;

	// cartridge configuration as seen on the register port
	logic [1:0]        cart_kind;
	logic              has_ram;
	logic [ROM_AW-1:0] rom_size_mask;
	logic [RAM_IW-1:0] ram_size_mask;

	// bank registers and cartridge ram
	logic [7:0] low_bank;
	logic [1:0] high_bank;
	logic [3:0] ram_page;
	logic       ram_on;
	logic       mode_sel;
	logic [7:0] cart_ram [DEF_RAM_BYTES];

	bus_response_t awaited [$];
	bus_response_t oldest;

	// cartridge ram slot for an access, zero when ram is absent or disabled
	function automatic logic ram_slot(input logic [15:0] addr, output logic [RAM_IW-1:0] slot);
		logic [31:0] offset;
		logic [31:0] bank;
		logic [31:0] idx;
		offset = 32'(addr) & RAM_OFFSET_MASK;
		slot = '0;
		if (!ram_on)
			return 1'b0;
		case (cart_kind)
			KIND_MBC1: begin
				if (!has_ram)
					return 1'b0;
				bank = mode_sel ? 32'(high_bank) : 32'd0;
				idx = ((bank * RAM_BANK_BYTES) | offset) & 32'(ram_size_mask);
			end
			KIND_MBC2: idx = offset & 32'(ram_size_mask) & 32'(MBC2_RAM_MASK);
			KIND_MBC5: begin
				if (!has_ram)
					return 1'b0;
				bank = 32'(ram_page);
				idx = ((bank * RAM_BANK_BYTES) | offset) & 32'(ram_size_mask);
			end
			default: return 1'b0;
		endcase
		slot = RAM_IW'(idx % DEF_RAM_BYTES);
		return 1'b1;
	endfunction

	// one bus access: update banks or ram and queue the response it yields
	task automatic serve_access(input logic [1:0] req, input logic [15:0] addr,
			input logic [7:0] data);
		bus_response_t resp;
		logic [RAM_IW-1:0] slot;
		logic [31:0] lb;
		logic [31:0] hb;
		logic [31:0] bank;
		logic [31:0] full;
		resp = '0;
		lb = 32'(low_bank);
		hb = 32'(high_bank);
		case (req)
			REQ_ROM_READ: begin
				if (addr <= ADDR_BANK0_TOP)
					bank = (cart_kind == KIND_MBC1 && mode_sel) ? (hb << MBC1_HIGH_SHIFT) : 32'd0;
				else begin
					case (cart_kind)
						KIND_NONE: bank = 32'd1;
						KIND_MBC1: bank = (hb << MBC1_HIGH_SHIFT) | lb;
						KIND_MBC2: bank = lb;
						default:   bank = (hb << MBC5_HIGH_SHIFT) | lb;
					endcase
				end
				full = ((bank * ROM_BANK_BYTES) | (32'(addr) & ROM_OFFSET_MASK))
					& 32'(rom_size_mask) & ((32'd1 << DEF_ROM_ADDR_BITS) - 32'd1);
				resp.rom_fetch = 1'b1;
				resp.rom_address = full[ROM_AW-1:0];
			end
			REQ_REG_WRITE: begin
				case (cart_kind)
					KIND_MBC1: begin
						if (addr <= ADDR_ENABLE_TOP)
							ram_on = (data[3:0] == ENABLE_CODE[3:0]);
						else if (addr <= ADDR_BANK0_TOP)
							low_bank = (data[4:0] == 5'd0) ? 8'd1 : {3'b000, data[4:0]};
						else if (addr <= ADDR_HIGH_TOP)
							high_bank = data[1:0];
						else
							mode_sel = data[0];
					end
					KIND_MBC2: begin
						// address bit 8 picks enable or rom bank
						if (addr <= ADDR_BANK0_TOP) begin
							if (!addr[8])
								ram_on = (data[3:0] == ENABLE_CODE[3:0]);
							else
								low_bank = (data[3:0] == 4'd0) ? 8'd1 : {4'h0, data[3:0]};
						end
					end
					KIND_MBC5: begin
						if (addr <= ADDR_ENABLE_TOP)
							ram_on = (data == ENABLE_CODE);
						else if (addr <= ADDR_MBC5_LOW)
							low_bank = data;
						else if (addr <= ADDR_BANK0_TOP)
							high_bank = {1'b0, data[0]};
						else if (addr <= ADDR_HIGH_TOP)
							ram_page = data[3:0];
					end
					default: ;
				endcase
			end
			REQ_RAM_READ: begin
				if (ram_slot(addr, slot)) begin
					resp.read_data = cart_ram[slot];
					if (cart_kind == KIND_MBC2)
						resp.read_data = NIBBLE_FILL | {4'h0, resp.read_data[3:0]};
				end else
					resp.read_data = RAM_FILL;
			end
			default: begin
				if (ram_slot(addr, slot))
					cart_ram[slot] = (cart_kind == KIND_MBC2) ? {4'h0, data[3:0]} : data;
			end
		endcase
		awaited.push_back(resp);
	endtask

	// follow config writes, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_kind = KIND_NONE;
			has_ram = 1'b0;
			rom_size_mask = ROM_MASK_RST;
			ram_size_mask = RAM_MASK_RST;
			low_bank = 8'd1;
			high_bank = 2'd0;
			ram_page = 4'd0;
			ram_on = 1'b0;
			mode_sel = 1'b0;
			for (int i = 0; i < DEF_RAM_BYTES; i++)
				cart_ram[i] = RAM_FILL;
			awaited.delete();
			responses_due = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_KIND:     cart_kind = cfg_data[1:0];
					CFG_RAM_PRES: has_ram = cfg_data[0];
					CFG_ROM_MASK: rom_size_mask = cfg_data[ROM_AW-1:0];
					CFG_RAM_MASK: ram_size_mask = cfg_data[RAM_IW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("response transfer with nothing awaited");
					mismatch_count++;
				end else begin
					oldest = awaited.pop_front();
					if (read_data !== oldest.read_data) begin
						$error("read_data expected %0h got %0h", oldest.read_data, read_data);
						mismatch_count++;
					end
					if (rom_fetch !== oldest.rom_fetch) begin
						$error("rom_fetch expected %0h got %0h", oldest.rom_fetch, rom_fetch);
						mismatch_count++;
					end
					if (rom_address !== oldest.rom_address) begin
						$error("rom_address expected %0h got %0h", oldest.rom_address,
							rom_address);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				serve_access(req_type, bus_address, write_data);
			responses_due = awaited.size();
		end
	end

endmodule

// ===== tb/tb_cartridge_bank_controller.sv =====
`timescale 1ns / 1ps

module tb_cartridge_bank_controller;
	import cbc_pkg::*;

	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 127;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam logic [15:0] RAM_WINDOW = 16'hA000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [1:0]        cfg_index = CFG_KIND;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic [1:0]        req_type = REQ_ROM_READ;
	logic [15:0]       bus_address = '0;
	logic [7:0]        write_data = '0;
	logic              out_stall = 1'b0;
	wire               in_stall;
	wire               out_valid;
	wire [7:0]         read_data;
	wire               rom_fetch;
	wire [ROM_AW-1:0]  rom_address;

	int mismatch_count;
	int responses_due;
	bit steady = 1'b0;
	logic [15:0] recent_ram [8];

	cartridge_bank_controller u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.bus_address (bus_address),
		.write_data  (write_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.rom_fetch   (rom_fetch),
		.rom_address (rom_address)
	);

	bank_access_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.bus_address    (bus_address),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.rom_fetch      (rom_fetch),
		.rom_address    (rom_address),
		.mismatch_count (mismatch_count),
		.responses_due  (responses_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// response side: a random hold-off after every transfer, none in steady mode
	logic out_took = 1'b0;
	int stall_left = 0;
	always @(posedge clk) begin
		out_took <= out_valid && !out_stall;
	end
	always @(negedge clk) begin
		if (out_took)
			stall_left = steady ? 0 : $urandom_range(0, 9);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else
			out_stall <= 1'b0;
	end

	// watchdog on cycles without any transfer; covers the ram clearing pass
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// one bus access transfer, after a random gap (none in steady mode)
	task automatic issue(input logic [1:0] req, input logic [15:0] addr, input logic [7:0] data);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		bus_address <= addr;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// hold off the bus until every response is back
	task automatic settle();
		in_valid <= 1'b0;
		wait (responses_due == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [1:0] kind, input logic present,
			input logic [ROM_AW-1:0] rmask, input logic [RAM_IW-1:0] amask);
		write_reg(CFG_KIND, CFG_W'(kind));
		write_reg(CFG_RAM_PRES, CFG_W'(present));
		write_reg(CFG_ROM_MASK, CFG_W'(rmask));
		write_reg(CFG_RAM_MASK, CFG_W'(amask));
		cfg_write <= 1'b0;
	endtask

	// mostly rom-area and ram-window accesses, biased toward enable codes
	task automatic random_access();
		int pick;
		logic [15:0] addr;
		logic [7:0] data;
		pick = $urandom_range(0, 99);
		addr = 16'($urandom);
		data = 8'($urandom);
		if (pick < 30) begin
			if ($urandom_range(0, 7) != 0)
				addr = 16'($urandom_range(0, 16'h7FFF));
			issue(REQ_ROM_READ, addr, data);
		end else if (pick < 55) begin
			if ($urandom_range(0, 7) != 0)
				addr = 16'($urandom_range(0, 16'h7FFF));
			if (addr <= ADDR_ENABLE_TOP && $urandom_range(0, 3) != 0)
				data = ($urandom_range(0, 1) != 0) ? ENABLE_CODE : {data[7:4], ENABLE_CODE[3:0]};
			issue(REQ_REG_WRITE, addr, data);
		end else if (pick < 80) begin
			if ($urandom_range(0, 1) != 0)
				addr = recent_ram[3'($urandom_range(0, 7))];
			else if ($urandom_range(0, 4) != 0)
				addr = RAM_WINDOW | {3'd0, addr[12:0]};
			issue(REQ_RAM_READ, addr, data);
		end else begin
			if ($urandom_range(0, 6) != 0)
				addr = RAM_WINDOW | {3'd0, addr[12:0]};
			recent_ram[3'($urandom_range(0, 7))] = addr;
			issue(REQ_RAM_WRITE, addr, data);
		end
	endtask

	initial begin
		logic [ROM_AW-1:0] rmask;
		logic [RAM_IW-1:0] amask;
		for (int i = 0; i < 8; i++)
			recent_ram[i] = RAM_WINDOW;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no controller at reset values: fixed bank one, ram absent
		issue(REQ_ROM_READ, 16'h4000, 8'h00);
		issue(REQ_RAM_READ, 16'hA000, 8'h00);
		issue(REQ_REG_WRITE, 16'h0000, ENABLE_CODE);
		settle();

		// mbc1: disabled ram, enable by low nibble, zero bank, mode 1
		load_config(KIND_MBC1, 1'b1, '1, '1);
		issue(REQ_ROM_READ, 16'h0000, 8'h00);
		issue(REQ_RAM_READ, 16'hA000, 8'h00);
		issue(REQ_REG_WRITE, 16'h0000, 8'h1A);
		issue(REQ_RAM_WRITE, 16'hA000, 8'h5A);
		issue(REQ_RAM_READ, 16'hA000, 8'h00);
		issue(REQ_REG_WRITE, 16'h2000, 8'h00);
		issue(REQ_REG_WRITE, 16'h4000, 8'h03);
		issue(REQ_REG_WRITE, 16'h6000, 8'h01);
		issue(REQ_ROM_READ, 16'h3FFF, 8'h00);
		issue(REQ_ROM_READ, 16'hFFFF, 8'h00);
		issue(REQ_RAM_WRITE, 16'hA123, 8'hFF);
		issue(REQ_RAM_READ, 16'hA123, 8'h00);
		settle();

		// mbc2: bank select by address bit 8, nibble ram, upper writes ignored
		load_config(KIND_MBC2, 1'b0, '1, '1);
		issue(REQ_REG_WRITE, 16'h0100, 8'h00);
		issue(REQ_REG_WRITE, 16'h4100, ENABLE_CODE);
		issue(REQ_RAM_WRITE, 16'hA3FF, 8'hAB);
		issue(REQ_RAM_READ, 16'hA1FF, 8'h00);
		issue(REQ_ROM_READ, 16'h7FFF, 8'h00);
		settle();

		// mbc5: 9-bit rom bank, ram bank, full-byte enable code
		load_config(KIND_MBC5, 1'b1, '1, '1);
		issue(REQ_REG_WRITE, 16'h3000, 8'h01);
		issue(REQ_REG_WRITE, 16'h2FFF, 8'hFF);
		issue(REQ_REG_WRITE, 16'h5FFF, 8'h0F);
		issue(REQ_ROM_READ, 16'h4000, 8'h00);
		issue(REQ_REG_WRITE, 16'h0000, 8'h1A);
		issue(REQ_RAM_READ, 16'hBFFF, 8'h00);
		issue(REQ_REG_WRITE, 16'h0000, ENABLE_CODE);
		issue(REQ_RAM_WRITE, 16'hBFFF, 8'h81);
		issue(REQ_RAM_READ, 16'hBFFF, 8'h00);
		settle();

		// random phases, each kind under a spread of mask settings
		for (int p = 0; p < PHASES; p++) begin
			case ((p + p / 4) % 4)
				0: rmask = '0;
				1: rmask = '1;
				2: rmask = (23'd1 << $urandom_range(14, 22)) - 23'd1;
				default: rmask = ROM_AW'($urandom);
			endcase
			case ((p * 3) % 5)
				0: amask = '0;
				1: amask = '1;
				2: amask = MBC2_RAM_MASK;
				3: amask = (17'd1 << $urandom_range(9, 16)) - 17'd1;
				default: amask = RAM_IW'($urandom);
			endcase
			load_config(2'(p % 4), (p % 3) != 0, rmask, amask);
			if ($urandom_range(0, 4) != 0)
				issue(REQ_REG_WRITE, 16'h0000, ENABLE_CODE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					steady = ($urandom_range(0, 3) == 0);
				if ((p == 0 && n == 60) || $urandom_range(0, 199) == 0)
					settle();
				random_access();
			end
			steady = 1'b0;
			settle();
		end

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && responses_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
